/* rtl/plc_pkg.sv */
`default_nettype none
package plc_pkg;

    localparam int MaxPoints = 16;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [3:0] REG_PERIODIC = 4'd0;
    localparam logic [3:0] REG_POINTS   = 4'd1;

    typedef struct packed {
        logic        command;
        logic [3:0]  point_index;
        logic [31:0] point_time;
        logic [31:0] point_value;
        logic [31:0] query_time;
    } plc_in_t;

    typedef struct packed {
        logic [31:0] curve_value;
        logic        is_evaluation;
    } plc_out_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input transaction
        logic load_write;  // write table slot
        logic mul_sum;     // add hi term to lo term
        logic [IdxW-1:0] rd_addr;
        logic rd_first;    // capture first point
        logic rd_last;     // capture last point
        logic rd_lo;       // capture lower bracket
        logic rd_hi;       // capture upper bracket
        logic wrap_start;  // start periodic modulo
        logic wrap_take;   // replace t with wrapped value
        logic frac_start;  // start fraction divide
        logic mul_lo;      // multiply lo term
        logic mul_hi;      // multiply hi term
        logic res_sel_lo;  // result = value lo
        logic res_sel_hi;  // result = value hi
        logic res_sel_first;
        logic res_sel_last;
        logic res_sel_blend;
        logic res_zero;
    } plc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_eval;
        logic t_lt_first;
        logic t_gt_last;
        logic span_empty;
        logic t_le_rd;     // t <= time at rd data
        logic t_le_lo;
        logic t_ge_hi;
        logic div_done;
    } plc_sts_t;

endpackage
`default_nettype wire

/* rtl/plc_divider.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle: 48-bit dividend / 32-bit divisor.
module plc_divider
    import plc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [47:0]      quotient,
    output logic [31:0]      remainder
);
    logic [47:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[47]};
        // remainder stays below divisor, so trial - divisor fits 33 bits signed
        diff      = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                r_next = diff[31:0];
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_next = trial[31:0];
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule
`default_nettype wire

/* rtl/plc_datapath.sv */
`default_nettype none
module plc_datapath
    import plc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire plc_in_t         in_data,
    input  wire plc_cmd_t        cmd,
    output plc_sts_t             sts,
    output logic [31:0]          result
);
    // breakpoint tables; valid bits give the all-zero reset
    logic [31:0] times_mem [MaxPoints];
    logic [31:0] values_mem [MaxPoints];
    logic [MaxPoints-1:0] vld_reg;
    logic [31:0] rd_time_reg, rd_val_reg;
    logic        rd_vld_reg;
    logic [31:0] rd_time, rd_val;

    plc_in_t     in_reg;
    logic [31:0] t_reg;
    logic [31:0] first_t_reg, first_v_reg, last_t_reg, last_v_reg;
    logic [31:0] lo_t_reg, lo_v_reg, hi_t_reg, hi_v_reg;
    logic        wrap_mode_reg;
    logic signed [49:0] acc_reg;
    logic signed [49:0] prod_reg;
    logic [31:0] result_reg;

    logic        div_start, div_done;
    logic [47:0] div_dividend, div_q;
    logic [31:0] div_divisor, div_r;
    logic [32:0] d_signed;
    logic [31:0] span;
    logic [15:0] frac;
    logic [16:0] wgt;
    logic signed [17:0] wgt_s;
    logic signed [31:0] mul_val;
    logic signed [49:0] mul_out;
    logic signed [49:0] blend_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.load_write)
            vld_reg[in_reg.point_index[IdxW-1:0]] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            times_mem[in_reg.point_index[IdxW-1:0]]  <= in_reg.point_time;
            values_mem[in_reg.point_index[IdxW-1:0]] <= in_reg.point_value;
        end
        rd_time_reg <= times_mem[cmd.rd_addr];
        rd_val_reg  <= values_mem[cmd.rd_addr];
        rd_vld_reg  <= vld_reg[cmd.rd_addr];
    end

    assign rd_time = rd_vld_reg ? rd_time_reg : 32'd0;
    assign rd_val  = rd_vld_reg ? rd_val_reg : 32'd0;

    // periodic wrap: |t - first| mod span, then floor correction
    assign span     = last_t_reg - first_t_reg;
    assign d_signed = {1'b0, t_reg} - {1'b0, first_t_reg};
    assign frac     = div_q[15:0];
    assign wgt      = wrap_mode_reg ? {1'b0, frac} : 17'd65536 - {1'b0, frac};
    assign wgt_s    = signed'({1'b0, wgt});
    assign mul_val  = signed'(cmd.mul_hi ? hi_v_reg : lo_v_reg);
    assign mul_out  = mul_val * wgt_s;

    always_comb
    begin
        div_start    = cmd.wrap_start || cmd.frac_start;
        div_dividend = '0;
        div_divisor  = span;
        if (cmd.wrap_start)
            div_dividend = {16'd0, d_signed[32] ? (first_t_reg - t_reg) : d_signed[31:0]};
        else
        begin
            div_dividend = {t_reg - lo_t_reg, 16'd0};
            div_divisor  = hi_t_reg - lo_t_reg;
        end
    end

    plc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign blend_q = acc_reg >>> 16;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
            t_reg  <= in_data.query_time;
        end
        if (cmd.rd_first)
        begin
            first_t_reg <= rd_time;
            first_v_reg <= rd_val;
        end
        if (cmd.rd_last)
        begin
            last_t_reg <= rd_time;
            last_v_reg <= rd_val;
        end
        if (cmd.rd_lo)
        begin
            lo_t_reg <= rd_time;
            lo_v_reg <= rd_val;
        end
        if (cmd.rd_hi)
        begin
            hi_t_reg <= rd_time;
            hi_v_reg <= rd_val;
        end
        if (cmd.wrap_start)
            wrap_mode_reg <= d_signed[32];
        if (cmd.frac_start)
            wrap_mode_reg <= 1'b0;
        if (cmd.wrap_take)
        begin
            if (wrap_mode_reg && div_r != 32'd0)
                t_reg <= first_t_reg + (span - div_r);
            else
                t_reg <= first_t_reg + div_r;
        end
        if (cmd.mul_lo)
        begin
            prod_reg      <= mul_out;
            wrap_mode_reg <= 1'b1;
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= mul_out;
            acc_reg  <= prod_reg;
        end
        if (cmd.mul_sum)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.res_sel_blend)
            result_reg <= blend_q[31:0];
        else if (cmd.res_sel_lo)
            result_reg <= lo_v_reg;
        else if (cmd.res_sel_hi)
            result_reg <= hi_v_reg;
        else if (cmd.res_sel_first)
            result_reg <= first_v_reg;
        else if (cmd.res_sel_last)
            result_reg <= last_v_reg;
        else if (cmd.res_zero)
            result_reg <= '0;
    end

    assign sts.is_eval    = in_reg.command == CMD_EVAL;
    assign sts.t_lt_first = t_reg < first_t_reg;
    assign sts.t_gt_last  = t_reg > last_t_reg;
    assign sts.span_empty = last_t_reg <= first_t_reg;
    assign sts.t_le_rd    = t_reg <= rd_time;
    assign sts.t_le_lo    = t_reg <= lo_t_reg;
    assign sts.t_ge_hi    = t_reg >= hi_t_reg;
    assign sts.div_done   = div_done;
    assign result         = result_reg;
endmodule
`default_nettype wire

/* rtl/plc_controller.sv */
`default_nettype none
module plc_controller
    import plc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_fire,
    input  wire logic            out_fire,
    input  wire logic            periodic,
    input  wire logic [4:0]      points,
    input  wire plc_sts_t        sts,
    output plc_cmd_t             cmd,
    output logic                 busy,
    output logic                 out_valid,
    output logic                 out_is_eval
);
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_RDF    = 14'b00000000000100,
        S_RDL    = 14'b00000000001000,
        S_CHECK  = 14'b00000000010000,
        S_WRAP   = 14'b00000000100000,
        S_SRCH   = 14'b00000001000000,
        S_RDLO   = 14'b00000010000000,
        S_DECIDE = 14'b00000100000000,
        S_FRAC   = 14'b00001000000000,
        S_MUL1   = 14'b00010000000000,
        S_MUL2   = 14'b00100000000000,
        S_SUM    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;   // read data valid next cycle
    logic            eval_reg, eval_next;
    logic [IdxW-1:0] last_idx;
    logic [4:0]      n_eff;

    always_comb
    begin
        if (points == 5'd0)
            n_eff = 5'd1;
        else if (points > 5'(MaxPoints))
            n_eff = 5'(MaxPoints);
        else
            n_eff = points;
    end
    assign last_idx = IdxW'(n_eff - 5'd1);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        eval_next  = eval_reg;
        cmd        = '0;
        cmd.rd_addr = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                eval_next = sts.is_eval;
                if (!sts.is_eval)
                begin
                    cmd.load_write = 1'b1;
                    cmd.res_zero   = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.rd_addr = '0;
                    state_next  = S_RDF;
                end
            end
            S_RDF:
            begin
                cmd.rd_first = 1'b1;
                cmd.rd_addr  = last_idx;
                state_next   = S_RDL;
            end
            S_RDL:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                idx_next   = IdxW'(1);
                if (n_eff == 5'd1)
                begin
                    cmd.res_sel_first = 1'b1;
                    state_next = S_OUT;
                end
                else if (periodic)
                begin
                    if (sts.span_empty)
                    begin
                        cmd.res_sel_first = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.wrap_start = 1'b1;
                        state_next = S_WRAP;
                    end
                end
                else if (sts.t_lt_first)
                begin
                    cmd.res_sel_first = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.t_gt_last)
                begin
                    cmd.res_sel_last = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_addr = IdxW'(1);
                    pend_next   = 1'b1;
                    state_next  = S_SRCH;
                end
            end
            S_WRAP:
            begin
                cmd.rd_addr = IdxW'(1);
                if (sts.div_done)
                begin
                    cmd.wrap_take = 1'b1;
                    pend_next     = 1'b1;
                    state_next    = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // one breakpoint per cycle, read data registered
                if (!pend_reg)
                begin
                    pend_next = 1'b1;
                end
                else if (sts.t_le_rd || 5'(idx_reg) == n_eff - 5'd1)
                begin
                    cmd.rd_hi   = 1'b1;
                    cmd.rd_addr = idx_reg - IdxW'(1);
                    state_next  = S_RDLO;
                end
                else
                begin
                    idx_next    = idx_reg + IdxW'(1);
                    cmd.rd_addr = idx_reg + IdxW'(1);
                    pend_next   = 1'b1;
                end
            end
            S_RDLO:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.t_le_lo)
                begin
                    cmd.res_sel_lo = 1'b1;
                    state_next = S_OUT;
                end
                else if (sts.t_ge_hi)
                begin
                    cmd.res_sel_hi = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.frac_start = 1'b1;
                    state_next = S_FRAC;
                end
            end
            S_FRAC:
            begin
                if (sts.div_done)
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_sum = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.res_sel_blend = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            eval_reg  <= eval_next;
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign out_valid   = state_reg == S_OUT;
    assign out_is_eval = eval_reg;
endmodule
`default_nettype wire

/* rtl/piecewise_linear_curve_eval_unit.sv */
`default_nettype none
// Load transaction: S_DECODE writes the table slot, then S_OUT holds a zero result until taken.
// Evaluate: S_RDF/S_RDL read the first and last points, and S_CHECK returns an end value or
// the single point; a table walk searches for k (k = upper bracket slot, 1..15), interpolation
// adds a serial divide and the S_MUL1, S_MUL2, S_SUM steps, periodic wrap another divide.
// One transaction at a time; the next is accepted the cycle after the result is taken.
// Reset (rst_n low, async) clears the table valid bits, periodic_mode=0, points_in_use=1.
module piecewise_linear_curve_eval_unit
    import plc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire plc_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output plc_out_t         out_data,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);
    logic       periodic_reg;
    logic [4:0] points_reg;
    plc_cmd_t   cmd;
    plc_sts_t   sts;
    logic       busy, is_eval;
    logic [31:0] result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            periodic_reg <= 1'b0;
            points_reg   <= 5'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PERIODIC)
                periodic_reg <= cfg_data[0];
            else if (cfg_index == REG_POINTS)
                points_reg <= cfg_data;
        end
    end

    assign in_stall = busy;

    plc_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_valid && !busy),
        .out_fire    (out_valid && !out_stall),
        .periodic    (periodic_reg),
        .points      (points_reg),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_is_eval (is_eval)
    );

    plc_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    assign out_data.curve_value   = result;
    assign out_data.is_evaluation = is_eval;
endmodule
`default_nettype wire

/* rtl/plc_checker.sv */
`default_nettype none
module plc_checker
    import plc_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_stall,
    input wire logic     out_valid,
    input wire logic     out_stall,
    input wire plc_out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_evaluation |-> out_data.curve_value == 32'd0)
        else $error("load acknowledgement not zero");
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !out_valid)
        else $error("transaction not taken up");
endmodule

bind piecewise_linear_curve_eval_unit plc_checker u_plc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
module testbench;
    import plc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    plc_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    plc_out_t    out_data;
    logic        cfg_we;
    logic [3:0]  cfg_index;
    logic [4:0]  cfg_data;

    piecewise_linear_curve_eval_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the curve table and registers
    logic [31:0]        bp_time [MaxPoints];
    logic signed [31:0] bp_val  [MaxPoints];
    logic               periodic_on;
    logic [4:0]         points_reg;

    plc_out_t    pending_results[$];
    int          errors;
    int          loads_sent;
    int          evals_sent;
    int          results_seen;
    int          curves_built;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_cycles;
    logic        typed_on;
    logic [31:0] typed_val;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] curve_at(logic [31:0] tq);
        int n;
        int k;
        longint span;
        longint d;
        longint r;
        longint a;
        longint s;
        longint t64;
        longint f64;
        logic [31:0] t;
        logic [31:0] tl;
        logic [31:0] tu;
        n = points_reg;
        if (n < 1) n = 1;
        if (n > MaxPoints) n = MaxPoints;
        if (n == 1) return bp_val[0];
        t = tq;
        if (periodic_on)
        begin
            if (bp_time[n-1] <= bp_time[0]) return bp_val[0];
            t64 = bp_time[n-1];
            f64 = bp_time[0];
            span = t64 - f64;
            t64 = t;
            d = t64 - f64;
            r = d % span;
            if (r < 0) r += span;
            t = bp_time[0] + r[31:0];
        end
        else
        begin
            if (t < bp_time[0]) return bp_val[0];
            if (t > bp_time[n-1]) return bp_val[n-1];
        end
        k = n - 1;
        for (int i = 1; i < n; i++)
        begin
            if (t <= bp_time[i])
            begin
                k = i;
                break;
            end
        end
        tl = bp_time[k-1];
        tu = bp_time[k];
        if (t <= tl) return bp_val[k-1];
        if (t >= tu) return bp_val[k];
        d = t - tl;
        span = tu - tl;
        a = (d << 16) / span;
        if (a > 65535) a = 65535;
        s = longint'(bp_val[k-1]) * (65536 - a) + longint'(bp_val[k]) * a;
        s = s >>> 16;
        return s[31:0];
    endfunction

    function automatic plc_out_t apply_transaction(plc_in_t it);
        plc_out_t res;
        if (it.command == CMD_LOAD)
        begin
            bp_time[it.point_index] = it.point_time;
            bp_val[it.point_index]  = it.point_value;
            res.curve_value   = '0;
            res.is_evaluation = 1'b0;
        end
        else
        begin
            res.curve_value   = curve_at(it.query_time);
            res.is_evaluation = 1'b1;
        end
        return res;
    endfunction

    // scoreboard: predict on input acceptance, compare on output acceptance
    always @(posedge clk)
    begin
        plc_out_t exp_res;
        plc_out_t got;
        if (rst_n && cfg_we)
        begin
            if (cfg_index == REG_PERIODIC) periodic_on = cfg_data[0];
            if (cfg_index == REG_POINTS) points_reg = cfg_data;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            exp_res = apply_transaction(in_data);
            if (typed_on) exp_res.curve_value = typed_val;
            pending_results = {pending_results, exp_res};
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = out_data;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction: value %h", got.curve_value);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got.curve_value !== exp_res.curve_value)
                begin
                    $error("curve_value: expected %h, got %h",
                           exp_res.curve_value, got.curve_value);
                    errors++;
                end
                if (got.is_evaluation !== exp_res.is_evaluation)
                begin
                    $error("is_evaluation: expected %b, got %b",
                           exp_res.is_evaluation, got.is_evaluation);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(plc_in_t it, bit typed, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        in_data   <= it;
        typed_on  <= typed;
        typed_val <= val;
        if (it.command == CMD_LOAD) loads_sent++;
        else evals_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        typed_on <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [4:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic plc_in_t mk_load(logic [3:0] idx, logic [31:0] t, logic [31:0] v);
        plc_in_t it;
        it.command     = CMD_LOAD;
        it.point_index = idx;
        it.point_time  = t;
        it.point_value = v;
        it.query_time  = $urandom;
        return it;
    endfunction

    function automatic plc_in_t mk_eval(logic [31:0] q);
        plc_in_t it;
        it.command     = CMD_EVAL;
        it.point_index = 4'($urandom);
        it.point_time  = $urandom;
        it.point_value = $urandom;
        it.query_time  = q;
        return it;
    endfunction

    typedef struct {
        bit          is_cfg;
        logic [3:0]  reg_idx;
        logic [4:0]  reg_val;
        plc_in_t     item;
        bit          typed;
        logic [31:0] exp_val;
    } step_t;

    step_t directed[$];

    task automatic add_item(plc_in_t it, bit typed, logic [31:0] val);
        step_t s;
        s.is_cfg = 0;
        s.item = it;
        s.typed = typed;
        s.exp_val = val;
        directed = {directed, s};
    endtask

    task automatic add_cfg(logic [3:0] idx, logic [4:0] val);
        step_t s;
        s.is_cfg = 1;
        s.reg_idx = idx;
        s.reg_val = val;
        directed = {directed, s};
    endtask

    // load a table of n points at rising times (these can wrap at 32 bits), then evaluate around it
    task automatic random_curve();
        int n;
        int n_eval;
        logic [31:0] t;
        logic [31:0] times [MaxPoints];
        logic [31:0] q;
        longint lo;
        longint hi;
        int step_max;
        n = ($urandom_range(9) == 0) ? MaxPoints : $urandom_range(1, 6);
        step_max = ($urandom_range(2) == 0) ? 32'h0fff_ffff : $urandom_range(1, 32'h0004_0000);
        t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
        for (int i = 0; i < n; i++)
        begin
            times[i] = t;
            send_item(mk_load(4'(i), t, $urandom), 0, '0);
            t = t + 1 + $urandom_range(0, step_max);
        end
        write_reg(REG_POINTS, 5'(n));
        write_reg(REG_PERIODIC, 5'($urandom_range(1)));
        curves_built++;
        lo = times[0];
        hi = times[n-1];
        n_eval = $urandom_range(6, 14);
        for (int i = 0; i < n_eval; i++)
        begin
            case ($urandom_range(5))
                0: q = $urandom;
                1: q = times[$urandom_range(n - 1)];
                2: q = times[$urandom_range(n - 1)] + $urandom_range(0, 2) - 1;
                default: q = 32'(lo - (hi - lo) / 2 + longint'($urandom) % (2 * (hi - lo) + 1));
            endcase
            send_item(mk_eval(q), 0, '0);
        end
    endtask

    task automatic random_noise();
        if ($urandom_range(1))
            send_item(mk_load(4'($urandom), $urandom, $urandom), 0, '0);
        else
            send_item(mk_eval($urandom), 0, '0);
    endtask

    initial
    begin
        int phase_items;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        typed_on = 1'b0;
        typed_val = '0;
        errors = 0;
        loads_sent = 0;
        evals_sent = 0;
        results_seen = 0;
        curves_built = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        periodic_on = 1'b0;
        points_reg = 5'd1;
        for (int i = 0; i < MaxPoints; i++)
        begin
            bp_time[i] = '0;
            bp_val[i] = '0;
        end

        // reset table, single point, clamp, exact hits, periodic wrap, empty span
        add_item(mk_eval(32'h0), 1, 32'h0);
        add_item(mk_load(4'd0, 32'h0001_0000, 32'h7fff_ffff), 1, 32'h0);
        add_item(mk_load(4'd1, 32'h0003_0000, 32'h8000_0000), 1, 32'h0);
        add_item(mk_load(4'd2, 32'h0004_0000, 32'h0), 1, 32'h0);
        add_item(mk_load(4'd3, 32'hffff_ffff, 32'h0001_0000), 1, 32'h0);
        add_item(mk_load(4'd15, 32'hffff_ffff, 32'h8000_0000), 1, 32'h0);
        add_item(mk_eval(32'hffff_ffff), 1, 32'h7fff_ffff);
        add_cfg(REG_POINTS, 5'd4);
        add_item(mk_eval(32'h0), 1, 32'h7fff_ffff);
        add_item(mk_eval(32'hffff_ffff), 1, 32'h0001_0000);
        add_item(mk_eval(32'h0003_0000), 1, 32'h8000_0000);
        add_item(mk_eval(32'h0002_0000), 0, '0);
        add_item(mk_eval(32'h0003_8000), 0, '0);
        add_cfg(REG_PERIODIC, 5'd1);
        add_item(mk_eval(32'h0), 0, '0);
        add_item(mk_eval(32'hffff_ffff), 0, '0);
        add_item(mk_eval(32'h0001_0000), 1, 32'h7fff_ffff);
        add_cfg(REG_POINTS, 5'd0);
        add_item(mk_eval(32'h0000_0005), 1, 32'h7fff_ffff);
        add_cfg(REG_POINTS, 5'd31);
        add_item(mk_eval(32'h1234_5678), 0, '0);
        add_cfg(REG_POINTS, 5'd2);
        add_item(mk_load(4'd1, 32'h0001_0000, 32'h0000_0005), 1, 32'h0);
        add_item(mk_eval(32'h0050_0000), 1, 32'h7fff_ffff);
        add_cfg(REG_PERIODIC, 5'd0);
        add_item(mk_eval(32'h0001_0000), 1, 32'h7fff_ffff);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            else
                send_item(directed[i].item, directed[i].typed, directed[i].exp_val);
        end
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 63 : 32) : 0;
            stall_pct = (ph == 2) ? 63 : ((ph == 3) ? 32 : 0);
            phase_items = loads_sent + evals_sent + 300;
            if (ph == 2) hold_cycles = 400;
            while (loads_sent + evals_sent < phase_items)
            begin
                if ($urandom_range(4) == 0) random_noise();
                else random_curve();
            end
            // sender waits for every outstanding result
            drain();
        end

        while (pending_results.size() != 0) @(negedge clk);
        repeat (150) @(negedge clk);
        $display("covered %0d loads, %0d evaluations, %0d random curves, %0d results checked",
                 loads_sent, evals_sent, curves_built, results_seen);
        $display("idle/stall phases: none, sender 63%%, receiver 63%% with long hold, both 32%%");
        if (errors == 0 && pending_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/plc_pkg.sv
rtl/plc_divider.sv
rtl/plc_datapath.sv
rtl/plc_controller.sv
rtl/piecewise_linear_curve_eval_unit.sv
rtl/plc_checker.sv
sim/testbench.sv
